FILE: design/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Shared constants, codes and types of the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

  // Geometry of the shared cell store
  localparam int CONSOLES          = 4;
  localparam int CELLS_PER_CONSOLE = 2048;
  localparam int STORE_CELLS       = CONSOLES * CELLS_PER_CONSOLE;

  localparam int CONS_W = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
  localparam int ADDR_W = $clog2(STORE_CELLS);
  localparam int LEN_W  = $clog2(CELLS_PER_CONSOLE + 1);
  localparam int SUM_W  = ((ADDR_W > LEN_W) ? ADDR_W : LEN_W) + 1;

  // Field widths
  localparam int KIND_W            = 2;
  localparam int KEY_CODE_W        = 8;
  localparam int CONSOLE_ID_W      = 2;
  localparam int CELL_INDEX_W      = 11;
  localparam int CURSOR_POSITION_W = 13;
  localparam int DISPLAY_START_W   = 13;
  localparam int LINE_LENGTH_W     = 12;
  localparam int CELL_WORD_W       = 16;
  localparam int ATTR_W            = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  // Editing keys
  localparam logic [KEY_CODE_W-1:0] KEY_DELETE = 8'h04;
  localparam logic [KEY_CODE_W-1:0] KEY_LEFT   = 8'h17;
  localparam logic [KEY_CODE_W-1:0] KEY_RIGHT  = 8'h18;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_KEY    = 2'd0,
    KIND_SWITCH = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [KEY_CODE_W-1:0]   key_code;
    logic [CONSOLE_ID_W-1:0] console_id;
    logic [CELL_INDEX_W-1:0] cell_index;
  } cle_req_t;

  typedef struct packed {
    logic [CURSOR_POSITION_W-1:0] cursor_position;
    logic [DISPLAY_START_W-1:0]   display_start;
    logic [LINE_LENGTH_W-1:0]     line_length;
    logic [CELL_WORD_W-1:0]       cell_word;
    logic                         dropped;
  } cle_rsp_t;

endpackage

FILE: design/cle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/cle_edit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_edit
// Edit sequencer: keeps per-console cursor and length, walks the cell store
// to open or close a gap, and builds the result of each transaction.
// ----------------------------------------------------------------------------
module cle_edit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cle_pkg::ATTR_W-1:0]        attr_i,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  cle_pkg::cle_req_t                 req_i,
  output logic                              rsp_valid_o,
  input  logic                              rsp_ready_i,
  output cle_pkg::cle_rsp_t                 rsp_o,
  output logic                              mem_we_o,
  output logic [cle_pkg::ADDR_W-1:0]        mem_waddr_o,
  output logic [cle_pkg::CELL_WORD_W-1:0]   mem_wdata_o,
  output logic [cle_pkg::ADDR_W-1:0]        mem_raddr_o,
  input  logic [cle_pkg::CELL_WORD_W-1:0]   mem_rdata_i
);

  import cle_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_INS   = 3'd3;
  localparam logic [2:0] ST_RDW   = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(CELLS_PER_CONSOLE);
  localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);

  logic [2:0]             state_q, state_d;
  logic [CONS_W-1:0]      cons_q, cons_d;
  logic [LEN_W-1:0]       cur_q [CONSOLES];
  logic [LEN_W-1:0]       cur_d [CONSOLES];
  logic [LEN_W-1:0]       len_q [CONSOLES];
  logic [LEN_W-1:0]       len_d [CONSOLES];
  logic [LEN_W-1:0]       ptr_q, ptr_d;
  logic [LEN_W-1:0]       last_q, last_d;
  logic                   is_ins_q, is_ins_d;
  logic                   wr_pend_q, wr_pend_d;
  logic [LEN_W-1:0]       wr_off_q, wr_off_d;
  logic [KEY_CODE_W-1:0]  key_q, key_d;
  logic [CELL_WORD_W-1:0] word_q, word_d;
  logic                   dropped_q, dropped_d;

  logic [ADDR_W-1:0]      base;
  logic [LEN_W-1:0]       cur, len;
  logic                   start;

  // Region base of the current console and its cursor and length
  assign base  = ADDR_W'(cons_q) * ADDR_W'(CELLS_PER_CONSOLE);
  assign cur   = cur_q[cons_q];
  assign len   = len_q[cons_q];
  assign start = req_valid_i && (state_q == ST_IDLE);

  assign req_ready_o = (state_q == ST_IDLE);

  // Memory ports: read address is the item index at start, else the walk pointer
  assign mem_raddr_o = (state_q == ST_IDLE) ? base + ADDR_W'(req_i.cell_index)
                                            : base + ADDR_W'(ptr_q);
  assign mem_we_o    = wr_pend_q || (state_q == ST_INS);
  assign mem_waddr_o = wr_pend_q ? base + ADDR_W'(wr_off_q) : base + ADDR_W'(cur);
  assign mem_wdata_o = wr_pend_q ? mem_rdata_i : {attr_i, key_q};

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cons_d    = cons_q;
    cur_d     = cur_q;
    len_d     = len_q;
    ptr_d     = ptr_q;
    last_d    = last_q;
    is_ins_d  = is_ins_q;
    wr_pend_d = 1'b0;
    wr_off_d  = wr_off_q;
    key_d     = key_q;
    word_d    = word_q;
    dropped_d = dropped_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          key_d     = req_i.key_code;
          word_d    = '0;
          dropped_d = 1'b0;
          state_d   = ST_RESP;
          unique case (req_i.kind)
            KIND_KEY: begin
              unique case (req_i.key_code)
                KEY_DELETE: begin
                  if (cur != '0) begin
                    if (cur < len) begin
                      // close the gap: move cells cur..len-1 down by one
                      ptr_d    = cur;
                      last_d   = len - LEN_ONE;
                      is_ins_d = 1'b0;
                      state_d  = ST_SHIFT;
                    end else begin
                      cur_d[cons_q] = cur - LEN_ONE;
                      len_d[cons_q] = len - LEN_ONE;
                    end
                  end
                end
                KEY_LEFT: begin
                  if (cur != '0) cur_d[cons_q] = cur - LEN_ONE;
                end
                KEY_RIGHT: begin
                  if (cur < len) cur_d[cons_q] = cur + LEN_ONE;
                end
                default: begin
                  if (len == LEN_FULL) begin
                    dropped_d = 1'b1;
                  end else if (len > cur) begin
                    // open the gap top down: move cells len-1..cur up by one
                    ptr_d    = len - LEN_ONE;
                    last_d   = cur;
                    is_ins_d = 1'b1;
                    state_d  = ST_SHIFT;
                  end else begin
                    state_d = ST_INS;
                  end
                end
              endcase
            end
            KIND_SWITCH: begin
              if (int'(req_i.console_id) < CONSOLES) cons_d = CONS_W'(req_i.console_id);
            end
            KIND_READ: begin
              if (int'(req_i.cell_index) < CELLS_PER_CONSOLE) state_d = ST_RDW;
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT: begin
        // read at ptr now, write the data one cell over next cycle
        wr_pend_d = 1'b1;
        wr_off_d  = is_ins_q ? ptr_q + LEN_ONE : ptr_q - LEN_ONE;
        if (ptr_q == last_q) begin
          state_d = ST_DRAIN;
        end else begin
          ptr_d = is_ins_q ? ptr_q - LEN_ONE : ptr_q + LEN_ONE;
        end
      end
      ST_DRAIN: begin
        if (is_ins_q) begin
          state_d = ST_INS;
        end else begin
          cur_d[cons_q] = cur - LEN_ONE;
          len_d[cons_q] = len - LEN_ONE;
          state_d       = ST_RESP;
        end
      end
      ST_INS: begin
        cur_d[cons_q] = cur + LEN_ONE;
        len_d[cons_q] = len + LEN_ONE;
        state_d       = ST_RESP;
      end
      ST_RDW: begin
        word_d  = mem_rdata_i;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (rsp_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cons_q    <= '0;
      wr_pend_q <= 1'b0;
      for (int c = 0; c < CONSOLES; c++) begin
        cur_q[c] <= '0;
        len_q[c] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cons_q    <= cons_d;
      wr_pend_q <= wr_pend_d;
      cur_q     <= cur_d;
      len_q     <= len_d;
    end
  end

  // Walk and result payload
  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    last_q    <= last_d;
    is_ins_q  <= is_ins_d;
    wr_off_q  <= wr_off_d;
    key_q     <= key_d;
    word_q    <= word_d;
    dropped_q <= dropped_d;
  end

  // Result of the transaction, reported from the updated state
  assign rsp_valid_o           = (state_q == ST_RESP);
  assign rsp_o.cursor_position = CURSOR_POSITION_W'(SUM_W'(base) + SUM_W'(cur));
  assign rsp_o.display_start   = DISPLAY_START_W'(base);
  assign rsp_o.line_length     = LINE_LENGTH_W'(len);
  assign rsp_o.cell_word       = word_q;
  assign rsp_o.dropped         = dropped_q;

`ifndef NO_ASSERTIONS
  // A pending write-back always follows a read of the walk
  a_pend_after_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> $past(state_q) == ST_SHIFT)
    else $error("write-back without a preceding walk read");

  // The new cell is written only after the shift has drained
  a_ins_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS) |-> !wr_pend_q)
    else $error("insert write collides with pending write-back");

  // Cursor stays within the text, text within the region
  a_cur_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur <= len) && (len <= LEN_FULL))
    else $error("cursor or length out of range");

  // A result waits, unchanged, until it is taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed before it was taken");
`endif

endmodule

FILE: design/console_line_editor_top.sv
`timescale 1ns / 1ps
// Flow: a switch, cursor move, ignored or refused key or delete at end of text goes straight to
// the result; a read or an insert at end of text first passes its cell read or write state; a
// mid-line delete or insert first walks the tail, one cell moved per cycle, and an insert then
// writes its cell. Throughput: one transaction at a time; the next is accepted once the result
// has loaded the output register. Reset (asynchronous,
// active low) clears cursors, lengths, console and attribute (to 7); cell store is not cleared.
// ----------------------------------------------------------------------------
// console_line_editor_top
// Line editor for several text consoles sharing one cell store.
// ----------------------------------------------------------------------------
module console_line_editor_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [cle_pkg::ATTR_W-1:0]              cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [cle_pkg::KIND_W-1:0]              kind_i,
  input  logic [cle_pkg::KEY_CODE_W-1:0]          key_code_i,
  input  logic [cle_pkg::CONSOLE_ID_W-1:0]        console_id_i,
  input  logic [cle_pkg::CELL_INDEX_W-1:0]        cell_index_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [cle_pkg::CURSOR_POSITION_W-1:0]   cursor_position_o,
  output logic [cle_pkg::DISPLAY_START_W-1:0]     display_start_o,
  output logic [cle_pkg::LINE_LENGTH_W-1:0]       line_length_o,
  output logic [cle_pkg::CELL_WORD_W-1:0]         cell_word_o,
  output logic                                    dropped_o
);

  import cle_pkg::*;

  logic [ATTR_W-1:0]      attr_q;
  cle_req_t               req;
  cle_rsp_t               rsp;
  cle_rsp_t               out_q;
  logic                   req_ready, rsp_valid, rsp_ready, load;
  logic                   out_valid_q, out_valid_d;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [CELL_WORD_W-1:0] mem_wdata, mem_rdata;

  // Attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // Input transaction
  assign req.kind       = kind_i;
  assign req.key_code   = key_code_i;
  assign req.console_id = console_id_i;
  assign req.cell_index = cell_index_i;
  assign in_stall_o     = !req_ready;

  cle_edit u_edit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .attr_i      (attr_q),
    .req_valid_i (in_valid_i),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  cle_ram #(
    .WIDTH (CELL_WORD_W),
    .DEPTH (STORE_CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: loads when empty or being drained
  assign rsp_ready   = !out_valid_q || !out_stall_i;
  assign load        = rsp_valid && rsp_ready;
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = out_q.cursor_position;
  assign display_start_o   = out_q.display_start;
  assign line_length_o     = out_q.line_length;
  assign cell_word_o       = out_q.cell_word;
  assign dropped_o         = out_q.dropped;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the console line editor. Keystroke, console switch,
// cell read and no-op transactions are sent with random gaps and checked
// against a cycle-free model of the consoles and their shared cell store. The
// output side stalls at random. The run covers cursor edges, mid-line tail
// shifts in both directions, several consoles and several attribute settings.
// ----------------------------------------------------------------------------
module tb_top;
  import cle_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  // Kind code outside the documented set: the block only reports its state
  localparam logic [KIND_W-1:0] KIND_IDLE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // Stimulus side
  logic                  cfg_we    = 1'b0;
  logic [ATTR_W-1:0]     cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  cle_req_t              req_q     = '0;
  logic                  out_stall = 1'b0;
  bit                    quiet_phase = 1'b0;

  // DUT outputs
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic [CURSOR_POSITION_W-1:0] cursor_position_o;
  logic [DISPLAY_START_W-1:0]   display_start_o;
  logic [LINE_LENGTH_W-1:0]     line_length_o;
  logic [CELL_WORD_W-1:0]       cell_word_o;
  logic                         dropped_o;

  // Pending transactions and the console status each one should produce
  cle_req_t request_q[$];
  cle_rsp_t status_due_q[$];

  // Console model
  logic [CELL_WORD_W-1:0] store_cells [STORE_CELLS];
  int unsigned cur_of [CONSOLES]  = '{default: 0};
  int unsigned len_of [CONSOLES]  = '{default: 0};
  int unsigned hw_mark [CONSOLES] = '{default: 0};  // cells written so far
  int unsigned sel_con = 0;
  logic [ATTR_W-1:0] attr_cfg = ATTR_RESET;

  // Bookkeeping
  int n_errors = 0;
  int n_in = 0;
  int n_checked = 0;
  int n_refused = 0;
  int n_reads = 0;
  int widest_shift = 0;
  int gap_left = 0;
  int stall_left = 0;
  longint cycle_cnt = 0;

  console_line_editor_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .kind_i            (req_q.kind),
    .key_code_i        (req_q.key_code),
    .console_id_i      (req_q.console_id),
    .cell_index_i      (req_q.cell_index),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .cursor_position_o (cursor_position_o),
    .display_start_o   (display_start_o),
    .line_length_o     (line_length_o),
    .cell_word_o       (cell_word_o),
    .dropped_o         (dropped_o)
  );

  always #10 clk_i = ~clk_i;

  // Apply one transaction to the console model and return the status it reports
  function automatic cle_rsp_t editor_step(cle_req_t req);
    cle_rsp_t    r;
    int unsigned base;
    int unsigned cur;
    int unsigned len;
    r    = '0;
    base = sel_con * CELLS_PER_CONSOLE;
    cur  = cur_of[sel_con];
    len  = len_of[sel_con];
    case (req.kind)
      KIND_KEY: begin
        if (req.key_code == KEY_DELETE) begin
          if (cur != 0) begin
            for (int unsigned i = cur; i < len; i++)
              store_cells[base + i - 1] = store_cells[base + i];
            if (len - cur > widest_shift) widest_shift = len - cur;
            cur_of[sel_con] = cur - 1;
            len_of[sel_con] = len - 1;
          end
        end else if (req.key_code == KEY_LEFT) begin
          if (cur > 0) cur_of[sel_con] = cur - 1;
        end else if (req.key_code == KEY_RIGHT) begin
          if (cur < len) cur_of[sel_con] = cur + 1;
        end else if (len >= CELLS_PER_CONSOLE) begin
          r.dropped = 1'b1;
          n_refused++;
        end else begin
          // open a gap at the cursor, top cell first
          for (int unsigned i = len; i > cur; i--)
            store_cells[base + i] = store_cells[base + i - 1];
          if (len - cur > widest_shift) widest_shift = len - cur;
          store_cells[base + cur] = {attr_cfg, req.key_code};
          cur_of[sel_con] = cur + 1;
          len_of[sel_con] = len + 1;
          if (len + 1 > hw_mark[sel_con]) hw_mark[sel_con] = len + 1;
        end
      end
      KIND_SWITCH: begin
        if (req.console_id < CONSOLES) sel_con = req.console_id;
      end
      KIND_READ: begin
        if (req.cell_index < CELLS_PER_CONSOLE) r.cell_word = store_cells[base + req.cell_index];
        n_reads++;
      end
      default: ;
    endcase
    base              = sel_con * CELLS_PER_CONSOLE;
    r.cursor_position = CURSOR_POSITION_W'(base + cur_of[sel_con]);
    r.display_start   = DISPLAY_START_W'(base);
    r.line_length     = LINE_LENGTH_W'(len_of[sel_con]);
    return r;
  endfunction

  // Any key code that is not an editing key
  function automatic logic [KEY_CODE_W-1:0] text_code();
    logic [KEY_CODE_W-1:0] k;
    do k = KEY_CODE_W'($urandom_range(255, 0));
    while (k == KEY_DELETE || k == KEY_LEFT || k == KEY_RIGHT);
    return k;
  endfunction

  // Queue one transaction; fields the kind does not use get random values
  task automatic queue_item(logic [KIND_W-1:0] kind, int unsigned value);
    cle_req_t r;
    r.kind       = kind;
    r.key_code   = KEY_CODE_W'($urandom_range(255, 0));
    r.console_id = CONSOLE_ID_W'($urandom_range(3, 0));
    r.cell_index = CELL_INDEX_W'($urandom_range(2047, 0));
    case (kind)
      KIND_KEY:    r.key_code   = value[KEY_CODE_W-1:0];
      KIND_SWITCH: r.console_id = value[CONSOLE_ID_W-1:0];
      KIND_READ:   r.cell_index = value[CELL_INDEX_W-1:0];
      default: ;
    endcase
    request_q.push_back(r);
  endtask

  // Wait until every queued transaction has been accepted
  task automatic wait_sent();
    while (request_q.size() != 0 || in_valid) @(negedge clk_i);
  endtask

  // Wait until the block is idle with nothing outstanding
  task automatic drain_all();
    wait_sent();
    while (status_due_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_attr(logic [ATTR_W-1:0] value);
    drain_all();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    attr_cfg   = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Read a cell that has been written (a text key if none is yet); the model state must be current first
  task automatic queue_written_read();
    wait_sent();
    if (hw_mark[sel_con] == 0) queue_item(KIND_KEY, text_code());
    else queue_item(KIND_READ, $urandom_range(hw_mark[sel_con] - 1, 0));
  endtask

  task automatic random_items(int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99, 0);
      if (pick < 35) queue_item(KIND_KEY, text_code());
      else if (pick < 45) queue_item(KIND_KEY, KEY_DELETE);
      else if (pick < 55) queue_item(KIND_KEY, KEY_LEFT);
      else if (pick < 65) queue_item(KIND_KEY, KEY_RIGHT);
      else if (pick < 78) queue_item(KIND_SWITCH, $urandom_range(3, 0));
      else if (pick < 95) queue_written_read();
      else queue_item(KIND_IDLE, 0);
    end
  endtask

  // Driver: one transaction at a time, random idle bursts between them
  always @(posedge clk_i or negedge rst_n) begin
    cle_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left  = 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        status_due_q.push_back(editor_step(req_q));
        n_in++;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0 && !quiet_phase) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          nxt       = request_q.pop_front();
          req_q    <= nxt;
          in_valid <= 1'b1;
          if (!quiet_phase && $urandom_range(5, 0) == 0) gap_left = $urandom_range(14, 1);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall bursts, compare each accepted result with the oldest due status
  always @(posedge clk_i or negedge rst_n) begin
    cle_rsp_t want;
    logic     stall_nxt;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (status_due_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("%0t: result with no transaction outstanding", $realtime);
        end else begin
          want = status_due_q.pop_front();
          n_checked++;
          if (cursor_position_o !== want.cursor_position ||
              display_start_o   !== want.display_start   ||
              line_length_o     !== want.line_length     ||
              cell_word_o       !== want.cell_word       ||
              dropped_o         !== want.dropped) begin
            n_errors++;
            if (n_errors <= 10)
              $display("%0t: exp/got cur %0d/%0d start %0d/%0d len %0d/%0d cell %h/%h drop %b/%b",
                       $realtime, want.cursor_position, cursor_position_o,
                       want.display_start, display_start_o, want.line_length, line_length_o,
                       want.cell_word, cell_word_o, want.dropped, dropped_o);
          end
        end
      end
      stall_nxt = 1'b0;
      if (!quiet_phase) begin
        if (stall_left > 0) begin
          stall_left--;
          stall_nxt = 1'b1;
        end else if ($urandom_range(7, 0) == 0) begin
          stall_left = $urandom_range(14, 1) - 1;
          stall_nxt  = 1'b1;
        end
      end
      out_stall <= stall_nxt;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed: edges of cursor movement, mid-line edits, reads, other consoles
    queue_item(KIND_KEY, KEY_DELETE);     // delete at cursor zero is ignored
    queue_item(KIND_KEY, KEY_LEFT);       // left at cursor zero
    queue_item(KIND_KEY, KEY_RIGHT);      // right at end of empty text
    queue_item(KIND_KEY, 8'h41);
    queue_item(KIND_KEY, 8'h00);
    queue_item(KIND_KEY, 8'hFF);
    queue_item(KIND_KEY, KEY_LEFT);
    queue_item(KIND_KEY, KEY_LEFT);
    queue_item(KIND_KEY, 8'h5A);          // insert mid-line, tail shifts up
    queue_item(KIND_KEY, KEY_RIGHT);
    queue_item(KIND_KEY, KEY_RIGHT);
    queue_item(KIND_KEY, KEY_RIGHT);      // right at end of text
    queue_item(KIND_READ, 0);
    queue_item(KIND_READ, 3);
    queue_item(KIND_KEY, KEY_LEFT);
    queue_item(KIND_KEY, KEY_DELETE);     // delete mid-line, tail closes up
    queue_item(KIND_READ, 3);             // past the text but written earlier
    queue_item(KIND_IDLE, 0);
    queue_item(KIND_SWITCH, 1);
    queue_item(KIND_KEY, 8'h20);
    queue_item(KIND_READ, 0);
    queue_item(KIND_SWITCH, 3);
    queue_item(KIND_SWITCH, 0);
    queue_item(KIND_READ, 1);

    write_attr(8'h00);
    random_items(12);

    write_attr(8'hFF);
    random_items(30);

    write_attr(ATTR_W'($urandom_range(254, 1)));
    random_items(44);

    // Final stretch without any idling on either side
    write_attr(8'h80);
    quiet_phase = 1'b1;
    random_items(30);

    drain_all();
    $display("Run: %0d transactions, %0d results checked, %0d reads, %0d refused inserts",
             n_in, n_checked, n_reads, n_refused);
    $display("Run: four consoles, attribute settings 07/00/FF/random/80, widest shift %0d cells",
             widest_shift);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/cle_pkg.sv
design/cle_ram.sv
design/cle_edit.sv
design/console_line_editor_top.sv
tb/sv/tb_top.sv
